// ===== hw/rtl/bsfp_pkg.sv =====
// Shared types and constants for the beacon sensor frame parser.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package bsfp_pkg;

  // Depth of the byte queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Frame-control flags.
  localparam logic [15:0] FLAG_ENCRYPTED = 16'h0008;
  localparam logic [15:0] FLAG_MAC       = 16'h0010;
  localparam logic [15:0] FLAG_CAP       = 16'h0020;
  localparam logic [15:0] FLAG_OBJ       = 16'h0040;

  // Object ids that carry sensor readings.
  localparam logic [15:0] ID_TEMP  = 16'h1004;
  localparam logic [15:0] ID_LUX   = 16'h1007;
  localparam logic [15:0] ID_MOIST = 16'h1008;
  localparam logic [15:0] ID_COND  = 16'h1009;
  localparam logic [15:0] ID_BATT  = 16'h100A;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_TRUNC     = 3'd1;
  localparam status_t ST_ENCRYPTED = 3'd2;
  localparam status_t ST_NOMAC     = 3'd3;
  localparam status_t ST_NOOBJ     = 3'd4;

  // One frame byte as it travels from the queue to the parser.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  // One parsed frame.
  typedef struct packed {
    status_t            status;
    logic        [15:0] device_model;
    logic        [7:0]  frame_counter;
    logic        [47:0] mac_address;
    logic signed [15:0] temperature_decidegc;
    logic        [23:0] illuminance_lux;
    logic        [7:0]  moisture_percent;
    logic        [15:0] soil_conductivity;
    logic        [7:0]  battery_percent;
    logic        [4:0]  valid_mask;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bsfp_if.sv =====
// Channel interfaces of the beacon sensor frame parser: byte input and result output.
// Depends on bsfp_pkg for the status type.
`timescale 1ns / 1ps
`default_nettype none

interface bsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bsfp_out_if;
  logic                 valid;
  logic                 ready;
  bsfp_pkg::status_t    status;
  logic        [15:0]   device_model;
  logic        [7:0]    frame_counter;
  logic        [47:0]   mac_address;
  logic signed [15:0]   temperature_decidegc;
  logic        [23:0]   illuminance_lux;
  logic        [7:0]    moisture_percent;
  logic        [15:0]   soil_conductivity;
  logic        [7:0]    battery_percent;
  logic        [4:0]    valid_mask;

  modport source (
    output valid, input ready,
    output status, output device_model, output frame_counter, output mac_address,
    output temperature_decidegc, output illuminance_lux, output moisture_percent,
    output soil_conductivity, output battery_percent, output valid_mask
  );
  modport sink (
    input valid, output ready,
    input status, input device_model, input frame_counter, input mac_address,
    input temperature_decidegc, input illuminance_lux, input moisture_percent,
    input soil_conductivity, input battery_percent, input valid_mask
  );
endinterface

`default_nettype wire

// ===== hw/rtl/bsfp_byte_queue.sv =====
// Front of the parser: accepts frame bytes and buffers them in a short queue.
// Depends on bsfp_pkg for the byte item type.
`timescale 1ns / 1ps
`default_nettype none

module bsfp_byte_queue #(
  parameter int DEPTH = 4
) (
  input  wire                     clk,
  input  wire                     rst_n,
  // Write side.
  input  wire                     push_valid,
  output logic                    push_ready,
  input  bsfp_pkg::byte_item_t    push_item,
  // Read side.
  output logic                    pop_valid,
  input  wire                     pop,
  output bsfp_pkg::byte_item_t    pop_item
);
  import bsfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  byte_item_t       slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop && pop_valid;

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset; the fill count guards it.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bsfp_parser.sv =====
// Back: walks the frame one byte per cycle, bar a stalled last byte; holds the result.
// Depends on bsfp_pkg for flags, object ids, status codes and the item types.
`timescale 1ns / 1ps
`default_nettype none

module bsfp_parser (
  input  wire                     clk,
  input  wire                     rst_n,
  // Byte side, from the queue.
  input  wire                     item_valid,
  input  bsfp_pkg::byte_item_t    item,
  output logic                    item_pop,
  // Result side.
  output logic                    res_valid,
  input  wire                     res_ready,
  output bsfp_pkg::result_t       res
);
  import bsfp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_MAC,
    PH_CAP,
    PH_OBJHDR,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  phase_t      phase_r,   phase_nxt;
  logic [3:0]  pos_r,     pos_nxt;
  logic [15:0] fc_r,      fc_nxt;
  logic [15:0] prod_r,    prod_nxt;
  logic [7:0]  cnt_r,     cnt_nxt;
  logic [47:0] mac_r,     mac_nxt;
  logic [15:0] obj_id_r,  obj_id_nxt;
  logic [7:0]  obj_len_r, obj_len_nxt;
  logic [7:0]  pidx_r,    pidx_nxt;
  logic [23:0] stage_r,   stage_nxt;
  logic [15:0] temp_r,    temp_nxt;
  logic [23:0] lux_r,     lux_nxt;
  logic [7:0]  moist_r,   moist_nxt;
  logic [15:0] cond_r,    cond_nxt;
  logic [7:0]  batt_r,    batt_nxt;
  logic [4:0]  vbits_r,   vbits_nxt;
  status_t     err_r,     err_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_r,     out_nxt;

  logic        take;
  logic        no_header;
  logic        no_mac;
  logic [7:0]  b;

  assign b         = item.data_byte;
  // A final byte waits until the result register is free; other bytes never stall.
  assign take      = item_valid && (!item.last_byte || !out_valid_r || res_ready);
  assign item_pop  = take;
  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    fc_nxt        = fc_r;
    prod_nxt      = prod_r;
    cnt_nxt       = cnt_r;
    mac_nxt       = mac_r;
    obj_id_nxt    = obj_id_r;
    obj_len_nxt   = obj_len_r;
    pidx_nxt      = pidx_r;
    stage_nxt     = stage_r;
    temp_nxt      = temp_r;
    lux_nxt       = lux_r;
    moist_nxt     = moist_r;
    cond_nxt      = cond_r;
    batt_nxt      = batt_r;
    vbits_nxt     = vbits_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !res_ready;
    out_nxt       = out_r;
    no_header     = 1'b0;
    no_mac        = 1'b0;

    if (take) begin
      // Per-byte phase update.
      case (phase_r)
        PH_HEADER: begin
          case (pos_r)
            4'd0:    fc_nxt        = {8'h00, b};
            4'd1:    fc_nxt[15:8]  = b;
            4'd2:    prod_nxt      = {8'h00, b};
            4'd3:    prod_nxt[15:8] = b;
            default: cnt_nxt       = b;
          endcase
          if (pos_r < 4'd4) begin
            pos_nxt = pos_r + 4'd1;
          end else if ((fc_r & FLAG_ENCRYPTED) != '0) begin
            err_nxt   = ST_ENCRYPTED;
            phase_nxt = PH_DONE;
          end else if ((fc_r & FLAG_MAC) == '0) begin
            err_nxt   = ST_NOMAC;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_MAC;
            pos_nxt   = '0;
          end
        end
        PH_MAC: begin
          mac_nxt[8*pos_r[2:0] +: 8] = b;
          if (pos_r < 4'd5) begin
            pos_nxt = pos_r + 4'd1;
          end else if ((fc_r & FLAG_CAP) != '0) begin
            phase_nxt = PH_CAP;
            pos_nxt   = '0;
          end else if ((fc_r & FLAG_OBJ) != '0) begin
            phase_nxt = PH_OBJHDR;
            pos_nxt   = '0;
          end else begin
            err_nxt   = ST_NOOBJ;
            phase_nxt = PH_DONE;
          end
        end
        PH_CAP: begin
          // The capability byte itself is skipped.
          if ((fc_r & FLAG_OBJ) != '0) begin
            phase_nxt = PH_OBJHDR;
            pos_nxt   = '0;
          end else begin
            err_nxt   = ST_NOOBJ;
            phase_nxt = PH_DONE;
          end
        end
        PH_OBJHDR: begin
          case (pos_r)
            4'd0: begin
              obj_id_nxt = {8'h00, b};
              pos_nxt    = 4'd1;
            end
            4'd1: begin
              obj_id_nxt[15:8] = b;
              pos_nxt          = 4'd2;
            end
            default: begin
              obj_len_nxt = b;
              pos_nxt     = '0;
              pidx_nxt    = '0;
              stage_nxt   = '0;
              if (b != 8'd0) begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          endcase
        end
        PH_PAYLOAD: begin
          // Only the first three payload bytes are kept.
          if (pidx_r < 8'd3) begin
            stage_nxt[8*pidx_r[1:0] +: 8] = b;
          end
          pidx_nxt = pidx_r + 8'd1;
          if (({1'b0, pidx_r} + 9'd1) >= {1'b0, obj_len_r}) begin
            // Object complete: commit a known reading if it is long enough.
            case (obj_id_r)
              ID_TEMP: begin
                if (obj_len_r >= 8'd2) begin
                  temp_nxt     = stage_nxt[15:0];
                  vbits_nxt[0] = 1'b1;
                end
              end
              ID_LUX: begin
                if (obj_len_r >= 8'd3) begin
                  lux_nxt      = stage_nxt;
                  vbits_nxt[1] = 1'b1;
                end
              end
              ID_MOIST: begin
                moist_nxt    = stage_nxt[7:0];
                vbits_nxt[2] = 1'b1;
              end
              ID_COND: begin
                if (obj_len_r >= 8'd2) begin
                  cond_nxt     = stage_nxt[15:0];
                  vbits_nxt[3] = 1'b1;
                end
              end
              ID_BATT: begin
                batt_nxt     = stage_nxt[7:0];
                vbits_nxt[4] = 1'b1;
              end
              default: ;
            endcase
            phase_nxt = PH_OBJHDR;
            pos_nxt   = '0;
          end
        end
        default: ;
      endcase

      // Final byte: build the result from the updated state, then clear it.
      if (item.last_byte) begin
        no_header = (err_nxt == ST_OK) && (phase_nxt == PH_HEADER);
        no_mac    = (err_nxt == ST_OK) && ((phase_nxt == PH_HEADER) || (phase_nxt == PH_MAC));

        if (err_nxt != ST_OK) begin
          out_nxt.status = err_nxt;
        end else if ((phase_nxt == PH_HEADER) || (phase_nxt == PH_MAC) ||
                     (phase_nxt == PH_CAP) || (phase_nxt == PH_PAYLOAD)) begin
          out_nxt.status = ST_TRUNC;
        end else begin
          out_nxt.status = ST_OK;
        end
        out_nxt.device_model         = no_header ? '0 : prod_nxt;
        out_nxt.frame_counter        = no_header ? '0 : cnt_nxt;
        out_nxt.mac_address          = no_mac ? '0 : mac_nxt;
        out_nxt.temperature_decidegc = temp_nxt;
        out_nxt.illuminance_lux      = lux_nxt;
        out_nxt.moisture_percent     = moist_nxt;
        out_nxt.soil_conductivity    = cond_nxt;
        out_nxt.battery_percent      = batt_nxt;
        out_nxt.valid_mask           = vbits_nxt;
        out_valid_nxt                = 1'b1;

        phase_nxt   = PH_HEADER;
        pos_nxt     = '0;
        fc_nxt      = '0;
        prod_nxt    = '0;
        cnt_nxt     = '0;
        mac_nxt     = '0;
        obj_id_nxt  = '0;
        obj_len_nxt = '0;
        pidx_nxt    = '0;
        stage_nxt   = '0;
        temp_nxt    = '0;
        lux_nxt     = '0;
        moist_nxt   = '0;
        cond_nxt    = '0;
        batt_nxt    = '0;
        vbits_nxt   = '0;
        err_nxt     = ST_OK;
      end
    end
  end

  // Parse state and the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      pos_r       <= '0;
      fc_r        <= '0;
      prod_r      <= '0;
      cnt_r       <= '0;
      mac_r       <= '0;
      obj_id_r    <= '0;
      obj_len_r   <= '0;
      pidx_r      <= '0;
      stage_r     <= '0;
      temp_r      <= '0;
      lux_r       <= '0;
      moist_r     <= '0;
      cond_r      <= '0;
      batt_r      <= '0;
      vbits_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      fc_r        <= fc_nxt;
      prod_r      <= prod_nxt;
      cnt_r       <= cnt_nxt;
      mac_r       <= mac_nxt;
      obj_id_r    <= obj_id_nxt;
      obj_len_r   <= obj_len_nxt;
      pidx_r      <= pidx_nxt;
      stage_r     <= stage_nxt;
      temp_r      <= temp_nxt;
      lux_r       <= lux_nxt;
      moist_r     <= moist_nxt;
      cond_r      <= cond_nxt;
      batt_r      <= batt_nxt;
      vbits_r     <= vbits_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/beacon_sensor_frame_parser.sv =====
// Beacon sensor frame parser: one frame byte per cycle in, one result per frame out.
// A result is registered in the parser once its final byte has left the queue.
// Throughput: one byte per cycle, set by the single-byte phase update in the parser;
// only a final byte waits, while the previous result is still held at the output.
// Reset: synchronous, active low; clears the queue, the parse state and the output valid.
// Depends on bsfp_pkg, bsfp_if, bsfp_byte_queue and bsfp_parser.
`timescale 1ns / 1ps
`default_nettype none

module beacon_sensor_frame_parser #(
  parameter int QUEUE_DEPTH = bsfp_pkg::QUEUE_DEPTH
) (
  input  wire          clk,
  input  wire          rst_n,
  bsfp_in_if.sink      in_ch,
  bsfp_out_if.source   out_ch
);
  import bsfp_pkg::*;

  byte_item_t in_item;
  byte_item_t q_item;
  logic       q_valid;
  logic       q_pop;
  result_t    res;

  assign in_item.data_byte = in_ch.data_byte;
  assign in_item.last_byte = in_ch.last_byte;

  // Front: accept bytes into the queue.
  bsfp_byte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_ch.valid),
    .push_ready (in_ch.ready),
    .push_item  (in_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // Back: parse bytes and hold the result.
  bsfp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item       (q_item),
    .item_pop   (q_pop),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res        (res)
  );

  assign out_ch.status               = res.status;
  assign out_ch.device_model         = res.device_model;
  assign out_ch.frame_counter        = res.frame_counter;
  assign out_ch.mac_address          = res.mac_address;
  assign out_ch.temperature_decidegc = res.temperature_decidegc;
  assign out_ch.illuminance_lux      = res.illuminance_lux;
  assign out_ch.moisture_percent     = res.moisture_percent;
  assign out_ch.soil_conductivity    = res.soil_conductivity;
  assign out_ch.battery_percent      = res.battery_percent;
  assign out_ch.valid_mask           = res.valid_mask;

endmodule

`default_nettype wire
